// ===== rtl/core/pds_pkg.sv =====
// Shared types and constants of the particle draw-order sorter.
`default_nettype none
package pds_pkg;

  localparam int IDX_W  = 16;
  localparam int POS_W  = 24;
  localparam int FWD_W  = 16;
  localparam int AGE_W  = 17;
  localparam int MODE_W = 3;
  localparam int KEY_W  = 53;
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIST   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEPTH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OLDEST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEWEST = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_FWD_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_FWD_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_FWD_Z = 3'd6;

  localparam logic [KEY_W-1:0] DEPTH_BIAS = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [AGE_W-1:0] AGE_ALL_ONES = {AGE_W{1'b1}};

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } pds_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] sort_mode;
    logic [POS_W-1:0]  cam_pos_x;
    logic [POS_W-1:0]  cam_pos_y;
    logic [POS_W-1:0]  cam_pos_z;
    logic [FWD_W-1:0]  cam_fwd_x;
    logic [FWD_W-1:0]  cam_fwd_y;
    logic [FWD_W-1:0]  cam_fwd_z;
  } pds_cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
    logic             last;
  } pds_item_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } pds_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/particle_draw_order_sorter.sv =====
// Top level of the particle draw-order sorter: registers, control, cell row.
// Particles are taken one per cycle. Each gets a key in a three-stage pipeline
// (differences, one multiplier per axis, sum and select) and is inserted from
// the stage-3 register into a row of MAX_PARTICLES cells kept sorted
// largest key first, equal keys in arrival order; a particle arriving with the
// row full is dropped. Once a particle flagged last is taken, intake pauses
// until that set has been inserted and emitted: the row shifts toward cell 0
// one index per output transfer, so output stall cycles lengthen the pause.
// end_of_list_o marks the final index.
`default_nettype none
module particle_draw_order_sorter import pds_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IDX_W-1:0]      particle_index_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [POS_W-1:0]      pos_z_i,
  input  logic [AGE_W-1:0]      age_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      sorted_index_o,
  output logic                  end_of_list_o
);

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  pds_cfg_t       cfg_q;
  pds_state_e     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic           in_xfer, out_xfer, full;
  logic           item_valid, last_in_flight;
  pds_item_t      item;
  pds_cell_ctrl_t ctrl;

  logic             less_w  [MAX_PARTICLES];
  logic [KEY_W-1:0] key_w   [MAX_PARTICLES];
  logic [IDX_W-1:0] index_w [MAX_PARTICLES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SORT_MODE: cfg_q.sort_mode <= cfg_wdata_i[MODE_W-1:0];
        CFG_CAM_POS_X: cfg_q.cam_pos_x <= cfg_wdata_i;
        CFG_CAM_POS_Y: cfg_q.cam_pos_y <= cfg_wdata_i;
        CFG_CAM_POS_Z: cfg_q.cam_pos_z <= cfg_wdata_i;
        CFG_CAM_FWD_X: cfg_q.cam_fwd_x <= cfg_wdata_i[FWD_W-1:0];
        CFG_CAM_FWD_Y: cfg_q.cam_fwd_y <= cfg_wdata_i[FWD_W-1:0];
        CFG_CAM_FWD_Z: cfg_q.cam_fwd_z <= cfg_wdata_i[FWD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign full     = (count_q == CNT_W'(MAX_PARTICLES));

  pds_key_unit u_key (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_xfer_i        (in_xfer),
    .particle_index_i (particle_index_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .age_i            (age_i),
    .is_last_i        (is_last_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .last_in_flight_o (last_in_flight)
  );

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ctrl.insert    = 1'b0;
    ctrl.shift_out = 1'b0;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o  = !last_in_flight;
        ctrl.insert = item_valid && !full;
        if (ctrl.insert) begin
          count_d = count_q + CNT_W'(1);
        end
        if (item_valid && item.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid_o    = 1'b1;
        ctrl.shift_out = out_xfer;
        if (out_xfer) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_FILL;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
    logic             prev_less;
    logic [KEY_W-1:0] prev_key, next_key;
    logic [IDX_W-1:0] prev_index, next_index;

    if (i == 0) begin : g_head
      assign prev_less  = 1'b0;
      assign prev_key   = '0;
      assign prev_index = '0;
    end else begin : g_body
      assign prev_less  = less_w[i-1];
      assign prev_key   = key_w[i-1];
      assign prev_index = index_w[i-1];
    end

    if (i == MAX_PARTICLES - 1) begin : g_tail
      assign next_key   = key_w[i];
      assign next_index = index_w[i];
    end else begin : g_inner
      assign next_key   = key_w[i+1];
      assign next_index = index_w[i+1];
    end

    pds_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CNT_W'(i) < count_q),
      .new_key_i    (item.key),
      .new_index_i  (item.index),
      .prev_less_i  (prev_less),
      .prev_key_i   (prev_key),
      .prev_index_i (prev_index),
      .next_key_i   (next_key),
      .next_index_i (next_index),
      .less_o       (less_w[i]),
      .key_o        (key_w[i]),
      .index_o      (index_w[i])
    );
  end

  assign sorted_index_o = index_w[0];
  assign end_of_list_o  = (count_q == CNT_W'(1));

endmodule
`default_nettype wire

// ===== rtl/core/pds_key_unit.sv =====
// Three-stage sort key pipeline: differences, products, key select.
`default_nettype none
module pds_key_unit import pds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pds_cfg_t         cfg_i,
  input  logic             in_xfer_i,
  input  logic [IDX_W-1:0] particle_index_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [POS_W-1:0] pos_z_i,
  input  logic [AGE_W-1:0] age_i,
  input  logic             is_last_i,
  output logic             item_valid_o,
  output pds_item_t        item_o,
  output logic             last_in_flight_o
);

  // stage 1
  logic                     s1_valid_q, s1_last_q;
  logic [MODE_W-1:0]        s1_mode_q;
  logic [IDX_W-1:0]         s1_index_q;
  logic [AGE_W-1:0]         s1_age_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [DIFF_W-1:0] s1_bx_q, s1_by_q, s1_bz_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [DIFF_W-1:0] bx_d, by_d, bz_d;

  // stage 2
  logic                     s2_valid_q, s2_last_q;
  logic [MODE_W-1:0]        s2_mode_q;
  logic [IDX_W-1:0]         s2_index_q;
  logic [AGE_W-1:0]         s2_age_q;
  logic signed [PROD_W-1:0] s2_px_q, s2_py_q, s2_pz_q;

  // stage 3
  logic                     s3_valid_q;
  pds_item_t                s3_item_q;
  logic signed [KEY_W-1:0]  sum;
  logic [KEY_W-1:0]         key_d;

  assign dx_d = $signed({pos_x_i[POS_W-1], pos_x_i})
              - $signed({cfg_i.cam_pos_x[POS_W-1], cfg_i.cam_pos_x});
  assign dy_d = $signed({pos_y_i[POS_W-1], pos_y_i})
              - $signed({cfg_i.cam_pos_y[POS_W-1], cfg_i.cam_pos_y});
  assign dz_d = $signed({pos_z_i[POS_W-1], pos_z_i})
              - $signed({cfg_i.cam_pos_z[POS_W-1], cfg_i.cam_pos_z});

  // second multiplier operand is taken with the particle
  assign bx_d = (cfg_i.sort_mode == MODE_DEPTH)
              ? $signed({{(DIFF_W-FWD_W){cfg_i.cam_fwd_x[FWD_W-1]}}, cfg_i.cam_fwd_x}) : dx_d;
  assign by_d = (cfg_i.sort_mode == MODE_DEPTH)
              ? $signed({{(DIFF_W-FWD_W){cfg_i.cam_fwd_y[FWD_W-1]}}, cfg_i.cam_fwd_y}) : dy_d;
  assign bz_d = (cfg_i.sort_mode == MODE_DEPTH)
              ? $signed({{(DIFF_W-FWD_W){cfg_i.cam_fwd_z[FWD_W-1]}}, cfg_i.cam_fwd_z}) : dz_d;

  assign sum = $signed({{(KEY_W-PROD_W){s2_px_q[PROD_W-1]}}, s2_px_q})
             + $signed({{(KEY_W-PROD_W){s2_py_q[PROD_W-1]}}, s2_py_q})
             + $signed({{(KEY_W-PROD_W){s2_pz_q[PROD_W-1]}}, s2_pz_q});

  always_comb begin
    case (s2_mode_q)
      MODE_DIST:   key_d = sum;
      MODE_DEPTH:  key_d = sum + DEPTH_BIAS;
      MODE_OLDEST: key_d = {{(KEY_W-AGE_W){1'b0}}, s2_age_q};
      MODE_NEWEST: key_d = {{(KEY_W-AGE_W){1'b0}}, AGE_ALL_ONES - s2_age_q};
      default:     key_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q  <= is_last_i;
    s1_mode_q  <= cfg_i.sort_mode;
    s1_index_q <= particle_index_i;
    s1_age_q   <= age_i;
    s1_dx_q    <= dx_d;
    s1_dy_q    <= dy_d;
    s1_dz_q    <= dz_d;
    s1_bx_q    <= bx_d;
    s1_by_q    <= by_d;
    s1_bz_q    <= bz_d;

    s2_last_q  <= s1_last_q;
    s2_mode_q  <= s1_mode_q;
    s2_index_q <= s1_index_q;
    s2_age_q   <= s1_age_q;
    s2_px_q    <= s1_dx_q * s1_bx_q;
    s2_py_q    <= s1_dy_q * s1_by_q;
    s2_pz_q    <= s1_dz_q * s1_bz_q;

    s3_item_q.key   <= key_d;
    s3_item_q.index <= s2_index_q;
    s3_item_q.last  <= s2_last_q;
  end

  assign item_valid_o     = s3_valid_q;
  assign item_o           = s3_item_q;
  assign last_in_flight_o = (s1_valid_q && s1_last_q) || (s2_valid_q && s2_last_q)
                         || (s3_valid_q && s3_item_q.last);

endmodule
`default_nettype wire

// ===== rtl/core/pds_cell.sv =====
// One insertion cell: holds a key and index, takes new, left or right data.
`default_nettype none
module pds_cell import pds_pkg::*; (
  input  logic             clk_i,
  input  pds_cell_ctrl_t   ctrl_i,
  input  logic             occupied_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [IDX_W-1:0] new_index_i,
  input  logic             prev_less_i,
  input  logic [KEY_W-1:0] prev_key_i,
  input  logic [IDX_W-1:0] prev_index_i,
  input  logic [KEY_W-1:0] next_key_i,
  input  logic [IDX_W-1:0] next_index_i,
  output logic             less_o,
  output logic [KEY_W-1:0] key_o,
  output logic [IDX_W-1:0] index_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0] index_q, index_d;

  // strict compare keeps earlier arrivals ahead on ties
  assign less_o = !occupied_i || (key_q < new_key_i);

  always_comb begin
    key_d   = key_q;
    index_d = index_q;
    if (ctrl_i.insert) begin
      if (prev_less_i) begin
        key_d   = prev_key_i;
        index_d = prev_index_i;
      end else if (less_o) begin
        key_d   = new_key_i;
        index_d = new_index_i;
      end
    end else if (ctrl_i.shift_out) begin
      key_d   = next_key_i;
      index_d = next_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    index_q <= index_d;
  end

  assign key_o   = key_q;
  assign index_o = index_q;

endmodule
`default_nettype wire

// ===== rtl/core/pds_checker.sv =====
// Port-level assertions for the particle draw-order sorter, bound to the top.
`default_nettype none
module pds_checker import pds_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  is_last_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [IDX_W-1:0]      sorted_index_o,
  input logic                  end_of_list_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sorted_index_o)
                                       && $stable(end_of_list_o)))
    else $error("stalled result changed");

  // intake is closed while a sorted run is emitted
  a_no_intake_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during output run");

  // a last particle closes intake on the next cycle
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && is_last_i) |=> !in_ready_o)
    else $error("intake open after last particle");

  // the run stops after its final index
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_list_o) |=> !out_valid_o)
    else $error("output continued past end of list");

endmodule

bind particle_draw_order_sorter pds_checker u_pds_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for particle_draw_order_sorter: directed plan, random sets, self-checking.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pds_pkg::*;

  localparam int MAX_PARTICLES = 64;
  localparam int RANDOM_ITEMS  = 75;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 500;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_UNUSED    = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [AGE_W-1:0] age;
    logic             is_last;
  } particle_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             eol;
  } draw_slot_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PARTICLE
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [CFG_DATA_W-1:0]  reg_val;
    particle_t              p;
    bit                     has_exp;
    logic [IDX_W-1:0]       exp_idx;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [IDX_W-1:0]      particle_index_i = '0;
  logic [POS_W-1:0]      pos_x_i = '0;
  logic [POS_W-1:0]      pos_y_i = '0;
  logic [POS_W-1:0]      pos_z_i = '0;
  logic [AGE_W-1:0]      age_i = '0;
  logic                  is_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IDX_W-1:0]      sorted_index_o;
  logic                  end_of_list_o;

  // predictor copy of the registers and the sorted list
  logic [MODE_W-1:0] cur_mode = MODE_NONE;
  logic [POS_W-1:0]  cam_x = '0, cam_y = '0, cam_z = '0;
  logic [FWD_W-1:0]  fwd_x = '0, fwd_y = '0, fwd_z = '0;
  logic [KEY_W-1:0]  list_keys[$];
  logic [IDX_W-1:0]  list_ids[$];
  draw_slot_t        draw_order_q[$];

  plan_row_t plan[$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  particles_sent = 0;
  int  sets_done = 0;
  int  dropped_count = 0;
  int  reg_writes = 0;
  int  burst_left = 0;
  bit  steady_send = 1'b0;
  bit  since_idle = 1'b0;

  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic [15:0] stall_pattern = '0;
  int          pattern_left = 0;

  particle_draw_order_sorter #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .particle_index_i (particle_index_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .age_i            (age_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sorted_index_o   (sorted_index_o),
    .end_of_list_o    (end_of_list_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d indices outstanding", cycle_count,
               draw_order_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void append_slot(ref draw_slot_t q[$], input draw_slot_t s);
    q.insert(q.size(), s);
  endfunction

  function automatic void apply_cfg_write(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DATA_W-1:0] val);
    case (sel)
      CFG_SORT_MODE: cur_mode = val[MODE_W-1:0];
      CFG_CAM_POS_X: cam_x = val[POS_W-1:0];
      CFG_CAM_POS_Y: cam_y = val[POS_W-1:0];
      CFG_CAM_POS_Z: cam_z = val[POS_W-1:0];
      CFG_CAM_FWD_X: fwd_x = val[FWD_W-1:0];
      CFG_CAM_FWD_Y: fwd_y = val[FWD_W-1:0];
      CFG_CAM_FWD_Z: fwd_z = val[FWD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] sort_key(particle_t p);
    longint dx, dy, dz, depth;
    logic [KEY_W-1:0] k;
    dx = $signed(p.pos_x) - $signed(cam_x);
    dy = $signed(p.pos_y) - $signed(cam_y);
    dz = $signed(p.pos_z) - $signed(cam_z);
    case (cur_mode)
      MODE_DIST: k = KEY_W'(dx * dx + dy * dy + dz * dz);
      MODE_DEPTH: begin
        depth = dx * $signed(fwd_x) + dy * $signed(fwd_y) + dz * $signed(fwd_z);
        k = KEY_W'(depth) + DEPTH_BIAS;
      end
      MODE_OLDEST: k = KEY_W'(p.age);
      MODE_NEWEST: k = KEY_W'(AGE_ALL_ONES - p.age);
      default: k = '0;
    endcase
    return k;
  endfunction

  // insert behind all keys that are not smaller; emit the list on the last particle
  function automatic void predict_draw_order(particle_t p, ref draw_slot_t emitted[$]);
    logic [KEY_W-1:0] k;
    int pos;
    if (list_keys.size() < MAX_PARTICLES) begin
      k = sort_key(p);
      pos = list_keys.size();
      for (int i = 0; i < list_keys.size(); i++) begin
        if (list_keys[i] < k) begin
          pos = i;
          break;
        end
      end
      list_keys.insert(pos, k);
      list_ids.insert(pos, p.idx);
    end else begin
      dropped_count++;
    end
    if (p.is_last) begin
      foreach (list_ids[i])
        append_slot(emitted, draw_slot_t'{list_ids[i], i == list_ids.size() - 1});
      list_keys.delete();
      list_ids.delete();
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg_write(sel, val);
    reg_writes++;
  endtask

  task automatic wait_idle();
    cfg_we_i <= 1'b0;
    in_valid_i <= 1'b0;
    while (draw_order_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    since_idle = 1'b0;
  endtask

  task automatic send_particle(particle_t p, bit has_exp, logic [IDX_W-1:0] exp_idx);
    int gap;
    draw_slot_t emitted[$];
    cfg_we_i <= 1'b0;
    if (burst_left == 0) begin
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    particle_index_i <= p.idx;
    pos_x_i <= p.pos_x;
    pos_y_i <= p.pos_y;
    pos_z_i <= p.pos_z;
    age_i <= p.age;
    is_last_i <= p.is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_draw_order(p, emitted);
    if (has_exp) append_slot(draw_order_q, draw_slot_t'{exp_idx, 1'b1});
    else foreach (emitted[i]) append_slot(draw_order_q, emitted[i]);
    particles_sent++;
    if (p.is_last) sets_done++;
    since_idle = 1'b1;
  endtask

  task automatic check_result(logic [IDX_W-1:0] idx, logic eol);
    draw_slot_t want;
    if (draw_order_q.size() == 0) begin
      report_mismatch($sformatf("index %h with nothing pending", idx));
    end else begin
      want = draw_order_q.pop_front();
      results_checked++;
      if (idx !== want.idx)
        report_mismatch($sformatf("sorted_index %h, want %h", idx, want.idx));
      if (eol !== want.eol)
        report_mismatch($sformatf("end_of_list %b, want %b at index %h", eol, want.eol,
                                  want.idx));
    end
  endtask

  // output side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(sorted_index_o, end_of_list_o);
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_pattern = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom() & $urandom());
        pattern_left = $urandom_range(20, 80);
      end else begin
        pattern_left--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_ready_i <= !stall_pattern[0];
    end
  end

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = val;
    r.p = '0;
    r.has_exp = 1'b0;
    r.exp_idx = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_particle(logic [IDX_W-1:0] idx, logic [POS_W-1:0] px,
                                       logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                                       logic [AGE_W-1:0] age, logic is_last,
                                       bit has_exp = 1'b0, logic [IDX_W-1:0] exp_idx = '0);
    plan_row_t r;
    r.kind = ROW_PARTICLE;
    r.reg_sel = '0;
    r.reg_val = '0;
    r.p = '{idx, px, py, pz, age, is_last};
    r.has_exp = has_exp;
    r.exp_idx = exp_idx;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [POS_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return POS_W'($urandom_range(0, 511)) - 24'd256;
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [AGE_W-1:0] rand_age();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'h10000;
      2: return AGE_ALL_ONES;
      3: return AGE_W'($urandom());
      default: return AGE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.idx = IDX_W'($urandom());
    p.pos_x = rand_coord();
    p.pos_y = rand_coord();
    p.pos_z = rand_coord();
    p.age = rand_age();
    p.is_last = 1'b0;
    return p;
  endfunction

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] val;
    logic [MODE_W-1:0] mode;
    logic [CFG_IDX_W-1:0] fwd_regs[3];
    logic [CFG_IDX_W-1:0] pos_regs[3];
    fwd_regs = '{CFG_CAM_FWD_X, CFG_CAM_FWD_Y, CFG_CAM_FWD_Z};
    pos_regs = '{CFG_CAM_POS_X, CFG_CAM_POS_Y, CFG_CAM_POS_Z};
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0: mode = MODE_NONE;
        1: mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED));
        2, 3: mode = MODE_DIST;
        4, 5: mode = MODE_DEPTH;
        6, 7: mode = MODE_OLDEST;
        default: mode = MODE_NEWEST;
      endcase
      val = CFG_DATA_W'($urandom());
      val[MODE_W-1:0] = mode;
      write_reg(CFG_SORT_MODE, val);
    end
    foreach (pos_regs[i])
      if ($urandom_range(0, 1) != 0) write_reg(pos_regs[i], rand_coord());
    foreach (fwd_regs[i]) begin
      if ($urandom_range(0, 1) != 0) begin
        val = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 5))
          0: val[FWD_W-1:0] = 16'h4000;
          1: val[FWD_W-1:0] = 16'hC000;
          2: val[FWD_W-1:0] = '0;
          3: ;
          default: val[FWD_W-1:0] = FWD_W'($urandom_range(0, 32768)) - 16'h4000;
        endcase
        write_reg(fwd_regs[i], val);
      end
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom()));
  endtask

  initial begin
    particle_t p;
    particle_t tie_pool[3];
    int random_items;
    int random_sets;
    int set_len;
    bit tie_set;
    bit overflow_done;
    bit chain_next;

    random_items = 0;
    random_sets = 0;
    overflow_done = 1'b0;
    chain_next = 1'b0;

    // reset settings: mode none, single particles and input order
    add_particle(16'h0000, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b1, 1'b1, 16'h0000);
    add_particle(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 17'h10000, 1'b1, 1'b1, 16'hFFFF);
    add_particle(16'h0005, 24'h000100, 24'h000000, 24'h000000, 17'h00001, 1'b0);
    add_particle(16'h0003, 24'h800000, 24'h000000, 24'h000000, 17'h1FFFF, 1'b0);
    add_particle(16'h0009, 24'h000000, 24'h7FFFFF, 24'h000000, 17'h08000, 1'b1);
    // distance, camera at the corners, with a tie
    add_cfg(CFG_SORT_MODE, CFG_DATA_W'(MODE_DIST));
    add_cfg(CFG_CAM_POS_X, 24'h800000);
    add_cfg(CFG_CAM_POS_Y, 24'h7FFFFF);
    add_particle(16'h0010, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 17'h00000, 1'b0);
    add_particle(16'h0011, 24'h800000, 24'h7FFFFF, 24'h000000, 17'h00000, 1'b0);
    add_particle(16'h0012, 24'h123456, 24'hFEDCBA, 24'h00FF00, 17'h00000, 1'b0);
    add_particle(16'h0013, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 17'h00000, 1'b1);
    // depth, mode upper bits masked off, forward z out of range
    add_cfg(CFG_SORT_MODE, {21'h1FFFFF, MODE_DEPTH});
    add_cfg(CFG_CAM_FWD_X, 24'h004000);
    add_cfg(CFG_CAM_FWD_Y, 24'hFFC000);
    add_cfg(CFG_CAM_FWD_Z, 24'h5A7FFF);
    add_cfg(CFG_CAM_POS_Z, 24'h800000);
    add_particle(16'h0020, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 17'h00000, 1'b0);
    add_particle(16'h0021, 24'h800000, 24'h7FFFFF, 24'h800000, 17'h00000, 1'b0);
    add_particle(16'h0022, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b0);
    add_particle(16'h0023, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b1);
    add_cfg(CFG_SORT_MODE, CFG_DATA_W'(MODE_OLDEST));
    add_particle(16'h0030, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b0);
    add_particle(16'h0031, 24'h000000, 24'h000000, 24'h000000, 17'h10000, 1'b0);
    add_particle(16'h0032, 24'h000000, 24'h000000, 24'h000000, 17'h1FFFF, 1'b0);
    add_particle(16'h0033, 24'h000000, 24'h000000, 24'h000000, 17'h10000, 1'b1);
    add_cfg(CFG_SORT_MODE, CFG_DATA_W'(MODE_NEWEST));
    add_particle(16'h0040, 24'h000000, 24'h000000, 24'h000000, 17'h1FFFF, 1'b0);
    add_particle(16'h0041, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b0);
    add_particle(16'h0042, 24'h000000, 24'h000000, 24'h000000, 17'h08000, 1'b1);
    // unused mode behaves as none; unknown register index is ignored
    add_cfg(CFG_SORT_MODE, CFG_DATA_W'(MODE_UNUSED));
    add_cfg(CFG_UNUSED_IDX, 24'hFFFFFF);
    add_particle(16'h0050, 24'h000000, 24'h000000, 24'h000000, 17'h1FFFF, 1'b0);
    add_particle(16'h0051, 24'h000000, 24'h000000, 24'h000000, 17'h00000, 1'b1);
    add_cfg(CFG_SORT_MODE, CFG_DATA_W'(MODE_OLDEST));
    add_particle(16'hA5A5, 24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F, 17'h0AAAA, 1'b1, 1'b1, 16'hA5A5);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (since_idle) wait_idle();
        write_reg(plan[r].reg_sel, plan[r].reg_val);
      end else begin
        send_particle(plan[r].p, plan[r].has_exp, plan[r].exp_idx);
      end
    end

    while (random_items < RANDOM_ITEMS || chain_next) begin
      if (!chain_next && (random_sets == 0 || $urandom_range(0, 2) != 0)) begin
        wait_idle();
        randomize_settings();
      end
      chain_next = 1'b0;
      if (!overflow_done) begin
        // overfill the list while the output is held off; next set follows at once
        set_len = MAX_PARTICLES + 3;
        overflow_done = 1'b1;
        chain_next = 1'b1;
        hold_toggle <= ~hold_toggle;
      end else if ($urandom_range(0, 4) == 0) begin
        set_len = $urandom_range(10, 24);
      end else begin
        set_len = $urandom_range(1, 6);
      end
      steady_send = ($urandom_range(0, 3) == 0);
      tie_set = ($urandom_range(0, 2) == 0);
      foreach (tie_pool[k]) tie_pool[k] = rand_particle();
      for (int j = 0; j < set_len; j++) begin
        p = tie_set ? tie_pool[$urandom_range(0, 2)] : rand_particle();
        p.idx = IDX_W'($urandom());
        p.is_last = (j == set_len - 1);
        send_particle(p, 1'b0, '0);
        random_items++;
      end
      random_sets++;
    end

    wait_idle();
    $display("covered %0d sets, %0d particles (%0d dropped on a full list), %0d indices checked",
             sets_done, particles_sent, dropped_count, results_checked);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
